/* rtl/tbl_pkg.sv */
// ----------------------------------------------------------------------------
// Tetrahedron locator package
// Shared widths, sequencer states and datapath command codes.
// ----------------------------------------------------------------------------
package tbl_pkg;

   localparam int CoordWidth   = 32;
   localparam int DiffWidth    = CoordWidth + 1;
   localparam int ProdWidth    = 2 * DiffWidth;
   localparam int DetWidth     = 3 * DiffWidth + 3;
   localparam int FracBits     = 28;
   localparam int NumWidth     = DetWidth + FracBits;
   localparam int QuoWidth     = NumWidth;
   localparam int QuoCntWidth  = $clog2(QuoWidth + 1);
   localparam int TolWidth     = 29;
   localparam int BaryWidth    = 32;
   localparam logic [TolWidth-1:0] TolReset = TolWidth'(268435);

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_DET,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_DIV_DONE,
      ST_FINISH
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic       load_diff;
      logic       det_step;
      logic [4:0] det_idx;
      logic       div_start;
      logic       div_step;
      logic [1:0] div_sel;
      logic       div_store;
      logic       finish;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic div_done;
      logic det_zero;
   } stat_type;

endpackage

/* rtl/tbl_datapath.sv */
// ----------------------------------------------------------------------------
// Tetrahedron locator datapath
// Vertex store, multipliers shared by all determinant terms, and a radix-2
// restoring divider shared by the three coordinate quotients.
// ----------------------------------------------------------------------------
module tbl_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load_en,
   input  logic [1:0]                            load_idx,
   input  logic                                  query_en,
   input  logic signed [tbl_pkg::CoordWidth-1:0] in_x,
   input  logic signed [tbl_pkg::CoordWidth-1:0] in_y,
   input  logic signed [tbl_pkg::CoordWidth-1:0] in_z,
   input  logic                                  csr_we,
   input  logic [tbl_pkg::TolWidth-1:0]          csr_wdata,
   input  tbl_pkg::cmd_type                      cmd,
   output tbl_pkg::stat_type                     stat,
   output logic signed [tbl_pkg::BaryWidth-1:0]  b1,
   output logic signed [tbl_pkg::BaryWidth-1:0]  b2,
   output logic signed [tbl_pkg::BaryWidth-1:0]  b3,
   output logic signed [tbl_pkg::BaryWidth-1:0]  b4,
   output logic                                  inside_flag,
   output logic                                  degen
);
   localparam int CW = tbl_pkg::CoordWidth;
   localparam int DW = tbl_pkg::DiffWidth;
   localparam int PW = tbl_pkg::ProdWidth;
   localparam int TW = tbl_pkg::DetWidth;
   localparam int NW = tbl_pkg::NumWidth;
   localparam int BW = tbl_pkg::BaryWidth;
   localparam int FB = tbl_pkg::FracBits;

   logic signed [CW-1:0] vx_ff [4];
   logic signed [CW-1:0] vy_ff [4];
   logic signed [CW-1:0] vz_ff [4];
   logic signed [CW-1:0] px_ff, py_ff, pz_ff;
   logic [tbl_pkg::TolWidth-1:0] tol_ff;

   // Edge vectors: a=V4-V1 b=V2-V1 c=V3-V1 p=P-V1 e=V4-V2 f=V3-V2 g=P-V2.
   logic signed [DW-1:0] dv_ff [7][3];

   // Vertex and tolerance registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            vx_ff[i] <= '0;
            vy_ff[i] <= '0;
            vz_ff[i] <= '0;
         end
         tol_ff <= tbl_pkg::TolReset;
      end else begin
         if (load_en) begin
            vx_ff[load_idx] <= in_x;
            vy_ff[load_idx] <= in_y;
            vz_ff[load_idx] <= in_z;
         end
         if (csr_we) begin
            tol_ff <= csr_wdata;
         end
      end
   end

   // Query point capture.
   always_ff @(posedge clock) begin
      if (query_en) begin
         px_ff <= in_x;
         py_ff <= in_y;
         pz_ff <= in_z;
      end
   end

   function automatic logic signed [DW-1:0] sub_ext(input logic signed [CW-1:0] a,
                                                    input logic signed [CW-1:0] b);
      return DW'(a) - DW'(b);
   endfunction

   // Difference vectors, formed once per query.
   always_ff @(posedge clock) begin
      if (cmd.load_diff) begin
         dv_ff[0][0] <= sub_ext(vx_ff[3], vx_ff[0]);
         dv_ff[0][1] <= sub_ext(vy_ff[3], vy_ff[0]);
         dv_ff[0][2] <= sub_ext(vz_ff[3], vz_ff[0]);
         dv_ff[1][0] <= sub_ext(vx_ff[1], vx_ff[0]);
         dv_ff[1][1] <= sub_ext(vy_ff[1], vy_ff[0]);
         dv_ff[1][2] <= sub_ext(vz_ff[1], vz_ff[0]);
         dv_ff[2][0] <= sub_ext(vx_ff[2], vx_ff[0]);
         dv_ff[2][1] <= sub_ext(vy_ff[2], vy_ff[0]);
         dv_ff[2][2] <= sub_ext(vz_ff[2], vz_ff[0]);
         dv_ff[3][0] <= sub_ext(px_ff, vx_ff[0]);
         dv_ff[3][1] <= sub_ext(py_ff, vy_ff[0]);
         dv_ff[3][2] <= sub_ext(pz_ff, vz_ff[0]);
         dv_ff[4][0] <= sub_ext(vx_ff[3], vx_ff[1]);
         dv_ff[4][1] <= sub_ext(vy_ff[3], vy_ff[1]);
         dv_ff[4][2] <= sub_ext(vz_ff[3], vz_ff[1]);
         dv_ff[5][0] <= sub_ext(vx_ff[2], vx_ff[1]);
         dv_ff[5][1] <= sub_ext(vy_ff[2], vy_ff[1]);
         dv_ff[5][2] <= sub_ext(vz_ff[2], vz_ff[1]);
         dv_ff[6][0] <= sub_ext(px_ff, vx_ff[1]);
         dv_ff[6][1] <= sub_ext(py_ff, vy_ff[1]);
         dv_ff[6][2] <= sub_ext(pz_ff, vz_ff[1]);
      end
   end

   // Determinant sequencing. The command index carries the determinant in
   // its upper two bits and the term (0..5) in its lower three; each term
   // takes three multiplier passes.
   // Determinant order: D (a,b,c), N3 (a,b,p), N2 (c,a,p), N1 (e,f,g).
   logic [4:0] idx;
   logic [2:0] term;
   logic [1:0] dsel;
   assign idx  = cmd.det_idx;
   assign dsel = idx[4:3];
   assign term = idx[2:0];

   logic [2:0] va, vb, vc;
   always_comb begin
      case (dsel)
         2'd0:    begin va = 3'd0; vb = 3'd1; vc = 3'd2; end
         2'd1:    begin va = 3'd0; vb = 3'd1; vc = 3'd3; end
         2'd2:    begin va = 3'd2; vb = 3'd0; vc = 3'd3; end
         default: begin va = 3'd4; vb = 3'd5; vc = 3'd6; end
      endcase
   end

   // Term selection: index pattern (i,j,k) and sign.
   logic [1:0] ti, tj, tk;
   logic       tneg;
   always_comb begin
      case (term)
         3'd0:    begin ti = 2'd0; tj = 2'd1; tk = 2'd2; tneg = 1'b0; end
         3'd1:    begin ti = 2'd0; tj = 2'd2; tk = 2'd1; tneg = 1'b1; end
         3'd2:    begin ti = 2'd1; tj = 2'd0; tk = 2'd2; tneg = 1'b1; end
         3'd3:    begin ti = 2'd1; tj = 2'd2; tk = 2'd0; tneg = 1'b0; end
         3'd4:    begin ti = 2'd2; tj = 2'd0; tk = 2'd1; tneg = 1'b0; end
         default: begin ti = 2'd2; tj = 2'd1; tk = 2'd0; tneg = 1'b1; end
      endcase
   end

   // Pass one multiplies two 33-bit values; passes two and three multiply the
   // registered product by the third factor in two halves (low then high).
   logic [1:0]            pass_ff;
   logic signed [PW-1:0]  prod_ff;
   logic signed [TW-1:0]  acc_ff;
   logic signed [TW-1:0]  part_ff;
   logic signed [DW-1:0]  fa, fb, fc;
   logic signed [PW-1:0]  mul1;
   logic [PW/2-1:0]       prod_lo;
   logic signed [PW/2:0]  prod_hi;
   logic signed [PW/2+DW+1:0] mul_lo, mul_hi;

   assign fa = dv_ff[va][ti];
   assign fb = dv_ff[vb][tj];
   assign fc = dv_ff[vc][tk];
   assign mul1 = fa * fb;
   assign prod_lo = prod_ff[PW/2-1:0];
   assign prod_hi = (PW/2+1)'(prod_ff >>> (PW/2));
   assign mul_lo = $signed({1'b0, prod_lo}) * fc;
   assign mul_hi = prod_hi * fc;

   logic signed [TW-1:0] det_ff [4];
   logic signed [TW-1:0] term_val;
   assign term_val = part_ff + (TW'(mul_hi) <<< (PW/2));

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff <= '0;
      end else if (cmd.load_diff) begin
         pass_ff <= '0;
      end else if (cmd.det_step) begin
         pass_ff <= pass_ff == 2'd2 ? 2'd0 : pass_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_diff) begin
         acc_ff <= '0;
      end else if (cmd.det_step) begin
         case (pass_ff)
            2'd0: prod_ff <= mul1;
            2'd1: part_ff <= TW'(mul_lo);
            default: begin
               if (term == 3'd5) begin
                  det_ff[dsel] <= tneg ? acc_ff - term_val : acc_ff + term_val;
                  acc_ff       <= '0;
               end else begin
                  acc_ff <= tneg ? acc_ff - term_val : acc_ff + term_val;
               end
            end
         endcase
      end
   end

   logic det_zero;
   assign det_zero = det_ff[0] == '0;

   // Restoring divider: |num| << FB + |D|/2 over |D|, one bit per cycle.
   logic [NW-1:0]        dividend_ff;
   logic [TW-1:0]        divisor_ff;
   logic [TW:0]          rem_ff;
   logic [NW-1:0]        quo_ff;
   logic [tbl_pkg::QuoCntWidth-1:0] cnt_ff;
   logic                 qneg_ff;
   logic signed [TW-1:0] num_sel;
   logic [TW-1:0]        an, ad;
   logic [TW:0]          rem_sh;
   logic [TW+1:0]        rem_sub;

   always_comb begin
      case (cmd.div_sel)
         2'd0:    num_sel = det_ff[3];
         2'd1:    num_sel = det_ff[2];
         default: num_sel = det_ff[1];
      endcase
   end
   assign an = num_sel[TW-1] ? TW'(-num_sel) : TW'(num_sel);
   assign ad = det_ff[0][TW-1] ? TW'(-det_ff[0]) : TW'(det_ff[0]);
   assign rem_sh  = {rem_ff[TW-1:0], dividend_ff[NW-1]};
   assign rem_sub = {1'b0, rem_sh} - {2'b00, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.div_start) begin
         cnt_ff <= tbl_pkg::QuoCntWidth'(NW);
      end else if (cmd.div_step && cnt_ff != '0) begin
         cnt_ff <= cnt_ff - tbl_pkg::QuoCntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dividend_ff <= ({an, FB'(0)}) + NW'(ad >> 1);
         divisor_ff  <= ad;
         rem_ff      <= '0;
         quo_ff      <= '0;
         qneg_ff     <= num_sel[TW-1] ^ det_ff[0][TW-1];
      end else if (cmd.div_step && cnt_ff != '0) begin
         dividend_ff <= dividend_ff << 1;
         if (!rem_sub[TW+1]) begin
            rem_ff <= rem_sub[TW:0];
            quo_ff <= {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[NW-2:0], 1'b0};
         end
      end
   end

   logic div_done;
   assign div_done = cnt_ff == '0;

   // Status back to the controller.
   assign stat = '{div_done: div_done, det_zero: det_zero};

   // Saturate, clamp and store the quotient.
   logic signed [BW:0]   qsat;
   logic                 big;
   logic signed [BW+1:0] one_s, lo_lim, hi_lim, qext;
   assign big = quo_ff[NW-1:BW] != '0;
   always_comb begin
      if (qneg_ff) begin
         qsat = (big || quo_ff[BW-1:0] > BW'(32'h8000_0000)) ?
                -(BW+1)'(33'h0_8000_0000) : -$signed({1'b0, quo_ff[BW-1:0]});
      end else begin
         qsat = (big || quo_ff[BW-1:0] > BW'(32'h7FFF_FFFF)) ?
                (BW+1)'(33'h0_7FFF_FFFF) : $signed({1'b0, quo_ff[BW-1:0]});
      end
   end
   assign one_s  = (BW+2)'(1) <<< FB;
   assign qext   = (BW+2)'(qsat);
   assign lo_lim = -$signed({5'b00000, tol_ff});
   assign hi_lim = one_s + $signed({5'b00000, tol_ff});

   logic signed [BW-1:0] bq_ff [3];
   logic                 in_ff;
   always_ff @(posedge clock) begin
      if (cmd.load_diff) begin
         in_ff <= 1'b1;
      end else if (cmd.div_store) begin
         if (qext < lo_lim) begin
            bq_ff[cmd.div_sel] <= '0;
            in_ff <= 1'b0;
         end else if (qext > hi_lim) begin
            bq_ff[cmd.div_sel] <= BW'(one_s);
            in_ff <= 1'b0;
         end else begin
            bq_ff[cmd.div_sel] <= BW'(qsat);
         end
      end
   end

   // Final word.
   logic signed [BW+2:0] fsum;
   assign fsum = (BW+3)'(one_s) - (BW+3)'(bq_ff[0]) - (BW+3)'(bq_ff[1])
                 - (BW+3)'(bq_ff[2]);
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (det_zero) begin
            b1 <= '0; b2 <= '0; b3 <= '0; b4 <= '0;
            inside_flag <= 1'b0;
            degen  <= 1'b1;
         end else begin
            b1 <= bq_ff[0];
            b2 <= bq_ff[1];
            b3 <= bq_ff[2];
            if (fsum > (BW+3)'(33'sh0_7FFF_FFFF)) begin
               b4 <= BW'(32'h7FFF_FFFF);
            end else if (fsum < -(BW+3)'(34'sh0_8000_0000)) begin
               b4 <= BW'(32'h8000_0000);
            end else begin
               b4 <= BW'(fsum);
            end
            inside_flag <= in_ff;
            degen  <= 1'b0;
         end
      end
   end

endmodule

/* rtl/tbl_control.sv */
// ----------------------------------------------------------------------------
// Tetrahedron locator controller
// Steps the shared multipliers over 72 passes and, for a nonzero determinant, the divider three times.
// ----------------------------------------------------------------------------
module tbl_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              query_en,
   input  tbl_pkg::stat_type stat,
   output tbl_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              done
);
   tbl_pkg::state_type state_ff, state_in;
   logic [4:0] idx_ff, idx_in;
   logic [1:0] pass_ff, pass_in;
   logic [1:0] sel_ff, sel_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tbl_pkg::ST_IDLE;
         idx_ff   <= '0;
         pass_ff  <= '0;
         sel_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pass_ff  <= pass_in;
         sel_ff   <= sel_in;
      end
   end

   // Next state and commands. The index holds the determinant in its upper
   // two bits and the term within it (0..5) in its lower three.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      pass_in  = pass_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      cmd.det_idx = idx_ff;
      cmd.div_sel = sel_ff;
      busy = 1'b1;
      done = 1'b0;
      case (state_ff)
         tbl_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (query_en) begin
               state_in = tbl_pkg::ST_DIFF;
            end
         end
         tbl_pkg::ST_DIFF: begin
            cmd.load_diff = 1'b1;
            idx_in   = '0;
            pass_in  = '0;
            state_in = tbl_pkg::ST_DET;
         end
         tbl_pkg::ST_DET: begin
            cmd.det_step = 1'b1;
            if (pass_ff == 2'd2) begin
               pass_in = '0;
               if (idx_ff == {2'd3, 3'd5}) begin
                  sel_in   = '0;
                  state_in = tbl_pkg::ST_DIV_START;
               end else if (idx_ff[2:0] == 3'd5) begin
                  idx_in = {idx_ff[4:3] + 2'd1, 3'd0};
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end else begin
               pass_in = pass_ff + 2'd1;
            end
         end
         tbl_pkg::ST_DIV_START: begin
            if (stat.det_zero) begin
               state_in = tbl_pkg::ST_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               state_in = tbl_pkg::ST_DIV_RUN;
            end
         end
         tbl_pkg::ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               state_in = tbl_pkg::ST_DIV_DONE;
            end
         end
         tbl_pkg::ST_DIV_DONE: begin
            cmd.div_store = 1'b1;
            if (sel_ff == 2'd2) begin
               state_in = tbl_pkg::ST_FINISH;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = tbl_pkg::ST_DIV_START;
            end
         end
         tbl_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            done = 1'b1;
            state_in = tbl_pkg::ST_IDLE;
         end
         default: state_in = tbl_pkg::ST_IDLE;
      endcase
   end

   // A query never starts while one is in flight.
   assert property (@(posedge clock) disable iff (reset)
      state_ff != tbl_pkg::ST_IDLE |-> busy)
      else $error("busy low outside idle");
   // Finishing always returns to idle.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == tbl_pkg::ST_FINISH |=> state_ff == tbl_pkg::ST_IDLE)
      else $error("finish did not return to idle");
   // The divider is started only with a nonzero determinant.
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !stat.det_zero)
      else $error("division by zero determinant");

endmodule

/* rtl/tet_barycentric_locator.sv */
// ----------------------------------------------------------------------------
// Tetrahedron barycentric locator
// Stores four vertices and returns the barycentric coordinates of a point.
// ----------------------------------------------------------------------------
// A load gives no word. A query word follows the accepting edge after one difference
// step, 72 multiplier passes, three divisions and one finish step (no divisions with
// a zero determinant). One query at a time: the block takes no new load or query
// until the finish step is done, and the receiver cannot stall the block.
// Synchronous reset clears the vertices to zero and the tolerance to default.
module tet_barycentric_locator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_action,
   input  logic [1:0]                           req_vertex_index,
   input  logic signed [31:0]                   req_coord_x,
   input  logic signed [31:0]                   req_coord_y,
   input  logic signed [31:0]                   req_coord_z,
   input  logic                                 csr_we,
   input  logic [28:0]                          csr_wdata,
   output logic                                 rsp_strobe,
   output logic signed [31:0]                   rsp_bary_first,
   output logic signed [31:0]                   rsp_bary_second,
   output logic signed [31:0]                   rsp_bary_third,
   output logic signed [31:0]                   rsp_bary_fourth,
   output logic                                 rsp_inside_res,
   output logic                                 rsp_degenerate
);
   logic              accept, load_en, query_en, done;
   tbl_pkg::cmd_type  cmd;
   tbl_pkg::stat_type stat;
   logic              strobe_ff;

   assign accept   = start && !busy;
   assign load_en  = accept && !req_action;
   assign query_en = accept && req_action;

   tbl_control u_control (
      .clock (clock), .reset (reset), .query_en (query_en),
      .stat (stat), .cmd (cmd), .busy (busy), .done (done)
   );

   tbl_datapath u_datapath (
      .clock (clock), .reset (reset), .load_en (load_en),
      .load_idx (req_vertex_index), .query_en (query_en),
      .in_x (req_coord_x), .in_y (req_coord_y), .in_z (req_coord_z),
      .csr_we (csr_we), .csr_wdata (csr_wdata), .cmd (cmd), .stat (stat),
      .b1 (rsp_bary_first), .b2 (rsp_bary_second), .b3 (rsp_bary_third),
      .b4 (rsp_bary_fourth), .inside_flag (rsp_inside_res),
      .degen (rsp_degenerate)
   );

   // Result strobe is registered from the finish step and rises in the cycle after it.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= done;
      end
   end
   assign rsp_strobe = strobe_ff;

endmodule

/* dv/tb_tet_barycentric_locator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tetrahedron barycentric locator testbench
// Loads tetrahedra and queries points through the command port, then
// checks every returned word against a typed expectation or a local
// bit-exact predictor built on wide signed arithmetic. A directed table comes
// first, then random tetrahedra and points under several tolerance settings.
// ----------------------------------------------------------------------------
module tb_tet_barycentric_locator;

   localparam logic ActLoad  = 1'b0;
   localparam logic ActQuery = 1'b1;
   localparam int   Unit     = 65536;
   localparam int   CycleLimit = 2000000;
   localparam int   DrainCycles = 600;
   localparam logic signed [31:0] BaryOne = 32'sh1000_0000;
   localparam logic [tbl_pkg::TolWidth-1:0] TolMax = tbl_pkg::TolWidth'(268435456);

   typedef logic signed [127:0] wide_type;
   typedef logic signed [33:0]  vec_type [3];

   typedef struct packed {
      logic signed [31:0] first;
      logic signed [31:0] second;
      logic signed [31:0] third;
      logic signed [31:0] fourth;
      logic               in_res;
      logic               degen;
   } bary_word_type;

   typedef struct packed {
      logic               action;
      logic [1:0]         index;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               typed;
      bary_word_type      want;
   } dir_row_type;

   localparam bary_word_type Degen = '{0, 0, 0, 0, 1'b0, 1'b1};
   localparam bary_word_type NoWant = '0;
   localparam int NumDir = 23;
   localparam logic signed [31:0] Pmax = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Nmax = 32'sh8000_0000;

   // Directed table: extremes, both actions, degenerate and flipped shapes.
   localparam dir_row_type DirRows [NumDir] = '{
      '{ActQuery, 2'd0, 0, 0, 0, 1'b1, Degen},
      '{ActQuery, 2'd3, Pmax, Nmax, -1, 1'b1, Degen},
      '{ActLoad, 2'd0, 0, 0, 0, 1'b0, NoWant},
      '{ActLoad, 2'd1, Unit, 0, 0, 1'b0, NoWant},
      '{ActLoad, 2'd2, 0, Unit, 0, 1'b0, NoWant},
      '{ActLoad, 2'd3, 0, 0, Unit, 1'b0, NoWant},
      '{ActQuery, 2'd0, 0, 0, 0, 1'b0, NoWant},
      '{ActQuery, 2'd1, Unit / 4, Unit / 4, Unit / 4, 1'b0, NoWant},
      '{ActQuery, 2'd2, Unit, 0, 0, 1'b0, NoWant},
      '{ActQuery, 2'd0, -Unit, -Unit, -Unit, 1'b0, NoWant},
      '{ActQuery, 2'd0, Pmax, Pmax, Pmax, 1'b0, NoWant},
      '{ActQuery, 2'd0, Nmax, Nmax, Nmax, 1'b0, NoWant},
      '{ActLoad, 2'd3, 0, 0, -Unit, 1'b0, NoWant},
      '{ActQuery, 2'd0, Unit / 4, Unit / 4, -Unit / 4, 1'b0, NoWant},
      '{ActLoad, 2'd2, Unit, 0, 0, 1'b0, NoWant},
      '{ActQuery, 2'd0, 12345, -678, 9, 1'b1, Degen},
      '{ActLoad, 2'd0, Nmax, Nmax, Nmax, 1'b0, NoWant},
      '{ActLoad, 2'd1, Pmax, Nmax, Nmax, 1'b0, NoWant},
      '{ActLoad, 2'd2, Nmax, Pmax, Nmax, 1'b0, NoWant},
      '{ActLoad, 2'd3, Nmax, Nmax, Pmax, 1'b0, NoWant},
      '{ActQuery, 2'd0, 0, 0, 0, 1'b0, NoWant},
      '{ActQuery, 2'd0, Pmax, Pmax, Pmax, 1'b0, NoWant},
      '{ActQuery, 2'd0, Nmax, Nmax, Nmax, 1'b0, NoWant}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_action = 1'b0;
   logic [1:0] req_vertex_index = '0;
   logic signed [31:0] req_coord_x = '0;
   logic signed [31:0] req_coord_y = '0;
   logic signed [31:0] req_coord_z = '0;
   logic csr_we = 1'b0;
   logic [tbl_pkg::TolWidth-1:0] csr_wdata = '0;
   logic rsp_strobe;
   logic signed [31:0] rsp_bary_first, rsp_bary_second, rsp_bary_third, rsp_bary_fourth;
   logic rsp_inside_res, rsp_degenerate;

   // Shadow of the vertex store and the tolerance register.
   logic signed [31:0] vert_x [4];
   logic signed [31:0] vert_y [4];
   logic signed [31:0] vert_z [4];
   logic [tbl_pkg::TolWidth-1:0] tolerance;
   bary_word_type pending_words [$];
   int errors = 0;
   int cycles = 0;
   int idle_pct = 22;

   tet_barycentric_locator DUT (.*);

   always #1 clock = ~clock;

   // Run guard.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("tet_barycentric_locator: mismatch");
         $finish;
      end
   end

   // 3x3 determinant, exact in 128 bits.
   function automatic wide_type det3(vec_type a, vec_type b, vec_type c);
      wide_type a0, a1, a2, b0, b1, b2, c0, c1, c2;
      a0 = a[0]; a1 = a[1]; a2 = a[2];
      b0 = b[0]; b1 = b[1]; b2 = b[2];
      c0 = c[0]; c1 = c[1]; c2 = c[2];
      return a0 * b1 * c2 - a0 * b2 * c1 - a1 * b0 * c2
           + a1 * b2 * c0 + a2 * b0 * c1 - a2 * b1 * c0;
   endfunction

   // Rounded, saturated quotient in the barycentric format.
   function automatic logic signed [63:0] bary_ratio(wide_type n, wide_type d);
      logic neg;
      logic [191:0] an, ad, q;
      neg = (n < 0) != (d < 0);
      an = (n < 0) ? 192'(-n) : 192'(n);
      ad = (d < 0) ? 192'(-d) : 192'(d);
      q = ((an << tbl_pkg::FracBits) + (ad >> 1)) / ad;
      if (neg) begin
         if (q > 192'h8000_0000) return -64'sh8000_0000;
         return -$signed(64'(q));
      end
      if (q > 192'h7FFF_FFFF) return 64'sh7FFF_FFFF;
      return $signed(64'(q));
   endfunction

   function automatic vec_type vert_diff(int hi, int lo);
      vec_type r;
      r[0] = 34'(vert_x[hi]) - 34'(vert_x[lo]);
      r[1] = 34'(vert_y[hi]) - 34'(vert_y[lo]);
      r[2] = 34'(vert_z[hi]) - 34'(vert_z[lo]);
      return r;
   endfunction

   function automatic bary_word_type locate_point(logic signed [31:0] px,
                                                  logic signed [31:0] py,
                                                  logic signed [31:0] pz);
      vec_type a, b, c, p1, p2;
      wide_type det, num [3];
      logic signed [63:0] q [3];
      logic signed [63:0] one, tol, sum;
      bary_word_type w;
      p1[0] = 34'(px) - 34'(vert_x[0]);
      p1[1] = 34'(py) - 34'(vert_y[0]);
      p1[2] = 34'(pz) - 34'(vert_z[0]);
      p2[0] = 34'(px) - 34'(vert_x[1]);
      p2[1] = 34'(py) - 34'(vert_y[1]);
      p2[2] = 34'(pz) - 34'(vert_z[1]);
      a = vert_diff(3, 0);
      b = vert_diff(1, 0);
      c = vert_diff(2, 0);
      det = det3(a, b, c);
      num[2] = det3(a, b, p1);
      num[1] = det3(c, a, p1);
      a = vert_diff(3, 1);
      b = vert_diff(2, 1);
      num[0] = det3(a, b, p2);
      if (det == 0) return Degen;
      one = 64'sd1 << tbl_pkg::FracBits;
      tol = 64'(tolerance);
      w.in_res = 1'b1;
      w.degen = 1'b0;
      for (int i = 0; i < 3; i++) begin
         q[i] = bary_ratio(num[i], det);
         if (q[i] < -tol) begin
            q[i] = 0;
            w.in_res = 1'b0;
         end else if (q[i] > one + tol) begin
            q[i] = one;
            w.in_res = 1'b0;
         end
      end
      sum = one - q[0] - q[1] - q[2];
      if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
      if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
      w.first = q[0][31:0];
      w.second = q[1][31:0];
      w.third = q[2][31:0];
      w.fourth = sum[31:0];
      return w;
   endfunction

   // Result checker: every strobed word is compared with the oldest expectation.
   always @(posedge clock) begin
      bary_word_type w;
      if (!reset && rsp_strobe) begin
         if (pending_words.size() == 0) begin
            $error("unexpected result word");
            errors++;
         end else begin
            w = pending_words.pop_front();
            if (rsp_bary_first !== w.first) begin
               $error("bary_first expected %0d got %0d", w.first, rsp_bary_first);
               errors++;
            end
            if (rsp_bary_second !== w.second) begin
               $error("bary_second expected %0d got %0d", w.second, rsp_bary_second);
               errors++;
            end
            if (rsp_bary_third !== w.third) begin
               $error("bary_third expected %0d got %0d", w.third, rsp_bary_third);
               errors++;
            end
            if (rsp_bary_fourth !== w.fourth) begin
               $error("bary_fourth expected %0d got %0d", w.fourth, rsp_bary_fourth);
               errors++;
            end
            if (rsp_inside_res !== w.in_res) begin
               $error("inside_res expected %0d got %0d", w.in_res, rsp_inside_res);
               errors++;
            end
            if (rsp_degenerate !== w.degen) begin
               $error("degenerate expected %0d got %0d", w.degen, rsp_degenerate);
               errors++;
            end
         end
      end
   end

   // Send one word; on acceptance update the shadow store or queue the answer.
   task automatic send_word(logic act, logic [1:0] idx, logic signed [31:0] x,
                            logic signed [31:0] y, logic signed [31:0] z,
                            logic typed, bary_word_type want);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_action <= act;
      req_vertex_index <= idx;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      do @(posedge clock); while (busy);
      if (act == ActLoad) begin
         vert_x[idx] = x;
         vert_y[idx] = y;
         vert_z[idx] = z;
      end else begin
         pending_words.push_back(typed ? want : locate_point(x, y, z));
      end
   endtask

   // Hold off until every answer is back and the block has gone quiet.
   task automatic drain();
      start <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [tbl_pkg::TolWidth-1:0] value);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      tolerance = value;
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(9))
         0: return $urandom;
         1: return $urandom_range(1) ? Pmax : Nmax;
         default: return $signed($urandom_range(0, 8 * Unit)) - 4 * Unit;
      endcase
   endfunction

   // Random tetrahedra, each followed by a burst of queries, mostly near it.
   task automatic random_phase(int count);
      int sent;
      logic signed [63:0] acc [3];
      int wt, total;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(9) == 0) begin
            // Noise: a lone load or query at an arbitrary point.
            send_word(1'($urandom_range(1)), 2'($urandom), rand_coord(), rand_coord(),
                      rand_coord(), 1'b0, NoWant);
            sent++;
         end else begin
            for (int k = 0; k < 4; k++) begin
               // Occasionally repeat a vertex to give a flat tetrahedron.
               if (k > 0 && $urandom_range(11) == 0)
                  send_word(ActLoad, 2'(k), vert_x[k - 1], vert_y[k - 1], vert_z[k - 1],
                            1'b0, NoWant);
               else
                  send_word(ActLoad, 2'(k), rand_coord(), rand_coord(), rand_coord(),
                            1'b0, NoWant);
            end
            sent += 4;
            repeat ($urandom_range(1, 5)) begin
               if ($urandom_range(2) == 0) begin
                  send_word(ActQuery, 2'($urandom), rand_coord(), rand_coord(),
                            rand_coord(), 1'b0, NoWant);
               end else begin
                  // Weighted blend of the vertices, mostly inside the shape.
                  acc = '{0, 0, 0};
                  total = 0;
                  for (int k = 0; k < 4; k++) begin
                     wt = $urandom_range(0, 8);
                     total += wt;
                     acc[0] += wt * 64'(vert_x[k]);
                     acc[1] += wt * 64'(vert_y[k]);
                     acc[2] += wt * 64'(vert_z[k]);
                  end
                  if (total == 0) total = 1;
                  send_word(ActQuery, 2'($urandom), 32'(acc[0] / total),
                            32'(acc[1] / total), 32'(acc[2] / total), 1'b0, NoWant);
               end
               sent++;
            end
         end
      end
   endtask

   initial begin
      tolerance = tbl_pkg::TolReset;
      for (int k = 0; k < 4; k++) begin
         vert_x[k] = 0;
         vert_y[k] = 0;
         vert_z[k] = 0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table at the reset tolerance.
      for (int r = 0; r < NumDir; r++)
         send_word(DirRows[r].action, DirRows[r].index, DirRows[r].x, DirRows[r].y,
                   DirRows[r].z, DirRows[r].typed, DirRows[r].want);

      write_tolerance('0);
      idle_pct = 0;
      random_phase(150);
      idle_pct = 22;
      random_phase(180);
      write_tolerance(TolMax);
      random_phase(300);
      write_tolerance(tbl_pkg::TolWidth'($urandom_range(0, 268435456)));
      random_phase(300);

      drain();
      if (errors == 0)
         $display("tet_barycentric_locator: match");
      else
         $display("tet_barycentric_locator: mismatch");
      $finish;
   end

endmodule
